[hw/rtl/wlfo_pkg.sv]
// Shared types and constants of the wavetable oscillator.
`timescale 1ns / 1ps
`default_nettype none

package wlfo_pkg;

   // Table geometry: the length must be a power of two.
   localparam int TABLE_LEN   = 1024;
   localparam int IDX_W       = $clog2(TABLE_LEN);
   localparam int FRAC_W      = 16;
   localparam int PHASE_W     = IDX_W + FRAC_W;
   localparam int RAMP_SHIFT  = FRAC_W - IDX_W;

   // Field widths of the channels.
   localparam int KIND_W      = 2;
   localparam int ENTRY_IDX_W = 10;
   localparam int SAMPLE_W    = 17;
   localparam int STEP_W      = 26;
   localparam int PROD_W      = 2 * SAMPLE_W;

   localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(1521);
   localparam logic [SAMPLE_W-1:0] ONE_Q16    = SAMPLE_W'(65536);

   // Result queue and the credit count that keeps it from overflowing.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int CREDIT_W   = $clog2(OUTQ_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PHASE_STEP = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_RESET = 2'd2
   } kind_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [SAMPLE_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } tbl_rd_type;

endpackage

`default_nettype wire

[hw/rtl/wlfo_if.sv]
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface wlfo_req_if;
   import wlfo_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic [SAMPLE_W-1:0]    entry_value;

   modport source (output valid, output kind, output entry_index, output entry_value,
                   input ready);
   modport sink   (input valid, input kind, input entry_index, input entry_value,
                   output ready);
endinterface

interface wlfo_rsp_if;
   import wlfo_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/wlfo_csr.sv]
// Register port holding the phase increment.
`timescale 1ns / 1ps
`default_nettype none

module wlfo_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wlfo_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [wlfo_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [wlfo_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output logic [wlfo_pkg::STEP_W-1:0]      phase_step
);
   import wlfo_pkg::*;

   logic [STEP_W-1:0]   step_ff;
   logic                wr_en;
   logic                sel_step;

   // Registers sit on 4-byte boundaries; bit 2 picks the register.
   assign sel_step = (paddr[2] == REG_PHASE_STEP);
   assign wr_en    = psel && penable && pwrite && pready;
   assign pready   = 1'b1;

   // Write of the step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (wr_en && sel_step) begin
         step_ff <= pwdata[STEP_W-1:0];
      end
   end

   // Read-back mux; unknown addresses read as zero.
   always_comb begin
      prdata = '0;
      if (sel_step) begin
         prdata = CSR_DATA_W'(step_ff);
      end
   end

   assign phase_step = step_ff;

endmodule

`default_nettype wire

[hw/rtl/wlfo_table.sv]
// Wave sample memory with two read ports, one write port and a ramp fill after reset.
`timescale 1ns / 1ps
`default_nettype none

module wlfo_table (
   input  logic                          clock,
   input  logic                          reset,
   input  wlfo_pkg::tbl_wr_type          wr,
   input  wlfo_pkg::tbl_rd_type          rd,
   output logic [wlfo_pkg::SAMPLE_W-1:0] rd_a,
   output logic [wlfo_pkg::SAMPLE_W-1:0] rd_b,
   output logic                          clearing
);
   import wlfo_pkg::*;

   logic [SAMPLE_W-1:0] wave_mem [TABLE_LEN];
   logic [SAMPLE_W-1:0] rd_a_ff;
   logic [SAMPLE_W-1:0] rd_b_ff;
   logic                clr_active_ff;
   logic [IDX_W-1:0]    clr_addr_ff;
   logic [SAMPLE_W-1:0] ramp_value;

   // Ramp entry i holds i * 65536 / TABLE_LEN.
   assign ramp_value = SAMPLE_W'(clr_addr_ff) << RAMP_SHIFT;

   // Fill sweep: one entry per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == IDX_W'(TABLE_LEN - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Memory array: the sweep owns the write port while it runs.
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         wave_mem[clr_addr_ff] <= ramp_value;
      end else if (wr.en) begin
         wave_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_a_ff <= wave_mem[rd.addr_a];
         rd_b_ff <= wave_mem[rd.addr_b];
      end
   end

   assign rd_a     = rd_a_ff;
   assign rd_b     = rd_b_ff;
   assign clearing = clr_active_ff;

endmodule

`default_nettype wire

[hw/rtl/wlfo_blend.sv]
// Two-weight linear interpolation between neighboring table samples.
`timescale 1ns / 1ps
`default_nettype none

module wlfo_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [wlfo_pkg::FRAC_W-1:0]   frac,
   input  logic [wlfo_pkg::SAMPLE_W-1:0] samp_a,
   input  logic [wlfo_pkg::SAMPLE_W-1:0] samp_b,
   output logic                          out_valid,
   output logic [wlfo_pkg::SAMPLE_W-1:0] out_sample
);
   import wlfo_pkg::*;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

   logic [SAMPLE_W-1:0] weight_a;
   logic [SAMPLE_W-1:0] weight_b;
   logic [PROD_W-1:0]   prod_a_ff;
   logic [PROD_W-1:0]   prod_b_ff;
   logic                valid_ff;
   logic [PROD_W:0]     sum;

   assign weight_b = SAMPLE_W'(frac);
   assign weight_a = ONE_Q16 - weight_b;

   // Product stage: the two weighted samples.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         prod_a_ff <= PROD_W'(weight_a) * PROD_W'(samp_a);
         prod_b_ff <= PROD_W'(weight_b) * PROD_W'(samp_b);
      end
   end

   // Sum, round half up and drop the fraction bits.
   assign sum        = (PROD_W + 1)'(prod_a_ff) + (PROD_W + 1)'(prod_b_ff) + ROUND_HALF;
   assign out_sample = sum[FRAC_W +: SAMPLE_W];
   assign out_valid  = valid_ff;

endmodule

`default_nettype wire

[hw/rtl/wlfo_outq.sv]
// Small result queue that decouples the pipeline from result backpressure.
`timescale 1ns / 1ps
`default_nettype none

module wlfo_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [wlfo_pkg::SAMPLE_W-1:0] push_data,
   wlfo_rsp_if.source                    rsp_chan
);
   import wlfo_pkg::*;

   logic [SAMPLE_W-1:0]   slot_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff;
   logic [CREDIT_W-1:0]   count_ff;
   logic                  pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUTQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUTQ_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CREDIT_W'(1);
            2'b01:   count_ff <= count_ff - CREDIT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid  = (count_ff != '0);
   assign rsp_chan.sample = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hw/rtl/wavetable_lfo_interpolated.sv]
// Top level of the interpolating wavetable oscillator.
// The block takes one request beat per clock cycle while req_chan.ready is high. A tick beat
// reads the two table entries around the phase in the cycle it is accepted; the table read
// register and the blend product register hold it in turn, and the sample is placed in
// a four-entry result queue. Load and phase-reset beats finish in the cycle they are accepted
// and give no result beat; a tick that directly follows a load already sees the new entry.
// The request side stalls while four ticks are in flight or queued and not yet taken, and
// while the table fill runs. After reset the table is filled with the ramp i/N, one entry
// per cycle, and no request is accepted until the fill ends; register writes are still taken.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_lfo_interpolated (
   input  logic                            clock,
   input  logic                            reset,
   wlfo_req_if.sink                        req_chan,
   wlfo_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wlfo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wlfo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wlfo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import wlfo_pkg::*;

   logic [STEP_W-1:0]   phase_step;
   logic [PHASE_W-1:0]  phase_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic                tick_ff;
   logic [CREDIT_W-1:0] credit_ff;
   logic                clearing;
   logic                req_acc;
   logic                is_tick;
   logic                is_load;
   logic                is_reset;
   logic                pop;
   logic [IDX_W-1:0]    idx_a;
   logic [SAMPLE_W-1:0] load_value;
   logic [SAMPLE_W-1:0] samp_a;
   logic [SAMPLE_W-1:0] samp_b;
   logic                blend_valid;
   logic [SAMPLE_W-1:0] blend_sample;
   tbl_wr_type          tbl_wr;
   tbl_rd_type          tbl_rd;

   wlfo_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .phase_step (phase_step)
   );

   // Request decode.
   assign req_chan.ready = !clearing && (credit_ff != CREDIT_W'(OUTQ_DEPTH));
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign is_tick  = req_acc && (req_chan.kind == KIND_TICK);
   assign is_load  = req_acc && (req_chan.kind == KIND_LOAD);
   assign is_reset = req_acc && (req_chan.kind == KIND_RESET);
   assign pop      = rsp_chan.valid && rsp_chan.ready;

   // Table access: neighbors of the phase, second index wrapping to zero.
   assign idx_a         = phase_ff[PHASE_W-1 -: IDX_W];
   assign tbl_rd.en     = is_tick;
   assign tbl_rd.addr_a = idx_a;
   assign tbl_rd.addr_b = idx_a + IDX_W'(1);

   // Loads saturate at 1.0 and ignore entries past the table end.
   assign load_value  = (req_chan.entry_value > ONE_Q16) ? ONE_Q16 : req_chan.entry_value;
   assign tbl_wr.en   = is_load && (int'(req_chan.entry_index) < TABLE_LEN);
   assign tbl_wr.addr = IDX_W'(req_chan.entry_index);
   assign tbl_wr.data = load_value;

   wlfo_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_a     (samp_a),
      .rd_b     (samp_b),
      .clearing (clearing)
   );

   // Phase accumulator wraps modulo the table span.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (is_tick) begin
         phase_ff <= phase_ff + PHASE_W'(phase_step);
      end else if (is_reset) begin
         phase_ff <= '0;
      end
   end

   // Fraction travels alongside the table read.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= 1'b0;
      end else begin
         tick_ff <= is_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (is_tick) begin
         frac_ff <= phase_ff[FRAC_W-1:0];
      end
   end

   // Credits: ticks accepted whose sample has not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         case ({is_tick, pop})
            2'b10:   credit_ff <= credit_ff + CREDIT_W'(1);
            2'b01:   credit_ff <= credit_ff - CREDIT_W'(1);
            default: credit_ff <= credit_ff;
         endcase
      end
   end

   wlfo_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tick_ff),
      .frac       (frac_ff),
      .samp_a     (samp_a),
      .samp_b     (samp_b),
      .out_valid  (blend_valid),
      .out_sample (blend_sample)
   );

   wlfo_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (blend_valid),
      .push_data (blend_sample),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
